// File: sv/ird_pkg.sv
// shared types, constants and fixed-point helpers for the inverse radial distortion block
package ird_pkg;

   localparam int WORD_W = 32;
   localparam int STOP_W = 31;
   localparam int IW = 64;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_K1 = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_K2 = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP = 2'd2;

   localparam logic signed [IW-1:0] SAT_MAX = 64'sh3FFF_FFFF_FFFF_FFFF;
   localparam logic signed [IW-1:0] RU_CAP = 64'sh0000_00FF_FFFF_FFFF;

   // point handed from the front end to the back end
   typedef struct packed {
      logic signed [WORD_W-1:0] x;
      logic signed [WORD_W-1:0] y;
      logic [IW-1:0] rd;
   } pt_type;

   function automatic logic [IW-1:0] mag(input logic signed [IW-1:0] v);
      mag = v[IW-1] ? IW'(-v) : IW'(v);
   endfunction

   function automatic logic signed [IW-1:0] sat_signed(input logic [127:0] m, input logic neg);
      logic [IW-1:0] v;
      v = (m[127:64] != '0 || m[63:0] > 64'(SAT_MAX)) ? 64'(SAT_MAX) : m[63:0];
      sat_signed = neg ? -$signed(v) : $signed(v);
   endfunction

   function automatic logic signed [IW-1:0] sat_add(input logic signed [IW-1:0] a,
                                                   input logic signed [IW-1:0] b);
      logic signed [IW:0] s;
      s = {a[IW-1], a} + {b[IW-1], b};
      if (s > 65'(SAT_MAX)) sat_add = SAT_MAX;
      else if (s < -65'(SAT_MAX)) sat_add = -SAT_MAX;
      else sat_add = s[IW-1:0];
   endfunction

endpackage

// File: sv/ird_mul.sv
// shared sequential 64x64 multiplier, four 32x32 partial products, one per cycle
module ird_mul (
   input logic clock,
   input logic reset,
   input logic start,
   input logic [63:0] a,
   input logic [63:0] b,
   output logic done,
   output logic [127:0] prod
);
   import ird_pkg::*;

   logic [63:0] a_ff, a_in, b_ff, b_in;
   logic [127:0] acc_ff, acc_in;
   logic [2:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [31:0] pa, pb;
   logic [63:0] pp;

   always_comb begin
      pa = cnt_ff[1] ? a_ff[63:32] : a_ff[31:0];
      pb = cnt_ff[0] ? b_ff[63:32] : b_ff[31:0];
      pp = 64'(pa) * 64'(pb);
      a_in = a_ff;
      b_in = b_ff;
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in = a;
         b_in = b;
         acc_in = '0;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = acc_ff + ({64'd0, pp} << (32 * (32'(cnt_ff[1]) + 32'(cnt_ff[0]))));
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff == 3'd3) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;
endmodule

// File: sv/ird_div.sv
// shared restoring divider, 128-bit dividend by 64-bit divisor, one bit per cycle
module ird_div (
   input logic clock,
   input logic reset,
   input logic start,
   input logic [127:0] num,
   input logic [63:0] den,
   output logic done,
   output logic [127:0] quo
);
   import ird_pkg::*;

   logic [127:0] q_ff, q_in;
   logic [64:0] rem_ff, rem_in;
   logic [63:0] d_ff, d_in;
   logic [6:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [64:0] sh;

   always_comb begin
      q_in = q_ff;
      rem_in = rem_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      sh = {rem_ff[63:0], q_ff[127]};
      if (start) begin
         q_in = num;
         rem_in = '0;
         d_in = den;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // quotient bits shift in where the dividend bits shift out
         if (sh >= {1'b0, d_ff}) begin
            rem_in = sh - {1'b0, d_ff};
            q_in = {q_ff[126:0], 1'b1};
         end else begin
            rem_in = sh;
            q_in = {q_ff[126:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd127) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      rem_ff <= rem_in;
      d_ff <= d_in;
   end

   assign done = done_ff;
   assign quo = q_ff;
endmodule

// File: sv/ird_front.sv
// front end: accepts points, computes the distorted radius, and feeds a two-entry queue
module ird_front (
   input logic clock,
   input logic reset,
   input logic push,
   output logic full,
   input logic signed [ird_pkg::WORD_W-1:0] dist_x,
   input logic signed [ird_pkg::WORD_W-1:0] dist_y,
   output logic q_empty,
   input logic q_pop,
   output ird_pkg::pt_type q_head
);
   import ird_pkg::*;

   typedef enum logic [1:0] {
      F_IDLE = 2'b01,
      F_ROOT = 2'b10
   } fstate_type;

   fstate_type st_ff, st_in;
   logic signed [WORD_W-1:0] x_ff, x_in, y_ff, y_in;
   logic [64:0] s_ff, s_in;
   logic [63:0] r_ff, r_in;
   logic [5:0] bit_ff, bit_in;
   pt_type q_mem [2];
   logic wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic qpush;
   logic [31:0] mx, my;
   logic [32:0] t;
   logic [65:0] tt;

   assign full = (st_ff != F_IDLE);
   assign q_empty = (cnt_ff == 2'd0);
   assign q_head = q_mem[rp_ff];

   always_comb begin
      st_in = st_ff;
      x_in = x_ff;
      y_in = y_ff;
      s_in = s_ff;
      r_in = r_ff;
      bit_in = bit_ff;
      qpush = 1'b0;
      mx = dist_x[31] ? 32'(-dist_x) : 32'(dist_x);
      my = dist_y[31] ? 32'(-dist_y) : 32'(dist_y);
      t = 33'(r_ff) | (33'd1 << bit_ff);
      tt = 66'(t) * 66'(t);
      unique case (st_ff)
         F_IDLE: begin
            if (push) begin
               x_in = dist_x;
               y_in = dist_y;
               s_in = 65'(64'(mx) * 64'(mx)) + 65'(64'(my) * 64'(my));
               r_in = '0;
               bit_in = 6'd32;
               st_in = F_ROOT;
            end
         end
         F_ROOT: begin
            // one root bit per cycle, last one held while queue full; squared operand is 33 bits at most
            if (tt <= 66'(s_ff)) r_in = 64'(t);
            bit_in = bit_ff - 6'd1;
            if (bit_ff == 6'd0 && cnt_ff != 2'd2) begin
               qpush = 1'b1;
               st_in = F_IDLE;
            end else if (bit_ff == 6'd0) begin
               bit_in = 6'd0;
               r_in = r_ff;
            end
         end
         default: st_in = F_IDLE;
      endcase
   end

   always_comb begin
      wp_in = wp_ff ^ qpush;
      rp_in = rp_ff ^ (q_pop && !q_empty);
      cnt_in = cnt_ff + 2'(qpush) - 2'(q_pop && !q_empty);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= F_IDLE;
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         st_ff <= st_in;
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      s_ff <= s_in;
      r_ff <= r_in;
      bit_ff <= bit_in;
      if (qpush) q_mem[wp_ff] <= '{x: x_ff, y: y_ff, rd: (tt <= 66'(s_ff)) ? 64'(t) : r_ff};
   end
endmodule

// File: sv/ird_back.sv
// back end: radius limit, newton search with bisection fallback, output scaling
module ird_back #(
   parameter int FRAC_BITS = 24,
   parameter int MAX_NEWTON_STEPS = 100
) (
   input logic clock,
   input logic reset,
   input logic signed [ird_pkg::WORD_W-1:0] k1,
   input logic signed [ird_pkg::WORD_W-1:0] k2,
   input logic [ird_pkg::STOP_W-1:0] stop,
   input logic q_empty,
   output logic q_pop,
   input ird_pkg::pt_type q_head,
   output logic rsp_empty,
   input logic rsp_pop,
   output logic signed [ird_pkg::WORD_W-1:0] undist_x,
   output logic signed [ird_pkg::WORD_W-1:0] undist_y
);
   import ird_pkg::*;

   localparam int SW = $clog2(MAX_NEWTON_STEPS + 1);
   localparam logic [63:0] ONE_Q = 64'd1 << FRAC_BITS;

   // one-hot sequencer; every arithmetic step waits on the shared units
   typedef enum logic [27:0] {
      S_IDLE   = 28'h0000001,
      S_L_A    = 28'h0000002,
      S_L_B    = 28'h0000004,
      S_L_SQ   = 28'h0000008,
      S_L_DIV  = 28'h0000010,
      S_L_RT   = 28'h0000020,
      S_N_RU2  = 28'h0000040,
      S_N_P1   = 28'h0000080,
      S_N_P2   = 28'h0000100,
      S_N_Q1   = 28'h0000200,
      S_N_Q2   = 28'h0000400,
      S_N_F    = 28'h0000800,
      S_N_DIV  = 28'h0001000,
      S_B_RU2  = 28'h0002000,
      S_B_Q1   = 28'h0004000,
      S_B_Q2   = 28'h0008000,
      S_B_F    = 28'h0010000,
      S_O_MX   = 28'h0020000,
      S_O_DX   = 28'h0040000,
      S_O_MY   = 28'h0080000,
      S_O_DY   = 28'h0100000,
      S_OUT    = 28'h0200000,
      S_L_K0   = 28'h0400000,
      S_L_RT2  = 28'h0800000,
      S_L_Z2   = 28'h1000000,
      S_N_START = 28'h2000000,
      S_B_START = 28'h4000000,
      S_L_K2   = 28'h8000000
   } bstate_type;

   bstate_type st_ff, st_in;
   pt_type pt_ff, pt_in;
   logic signed [63:0] rumax_ff, rumax_in, ru_ff, ru_in, ru2_ff, ru2_in;
   logic signed [63:0] t1_ff, t1_in, slope_ff, slope_in, lo_ff, lo_in, hi_ff, hi_in;
   logic signed [63:0] s_ff, s_in;
   logic [SW-1:0] it_ff, it_in;
   logic [6:0] bn_ff, bn_in;
   logic z2_ff, z2_in;
   logic [127:0] acc_ff, acc_in;
   logic [6:0] rb_ff, rb_in;
   logic [63:0] rr_ff, rr_in;
   logic signed [31:0] ox_ff, ox_in, oy_ff, oy_in;
   logic out_ff, out_in;

   logic m_start, d_start, m_done, d_done;
   logic [63:0] m_a, m_b, d_den;
   logic [127:0] m_p, d_num, d_q;
   logic [63:0] prec, rtry;
   logic signed [63:0] mq, dq, fval, nxt, den10;
   logic neg_ff, neg_in;

   ird_mul u_mul (.clock, .reset, .start(m_start), .a(m_a), .b(m_b), .done(m_done),
                  .prod(m_p));
   ird_div u_div (.clock, .reset, .start(d_start), .num(d_num), .den(d_den), .done(d_done),
                  .quo(d_q));

   assign rsp_empty = !out_ff;
   assign undist_x = ox_ff;
   assign undist_y = oy_ff;
   assign prec = (stop == '0) ? 64'd1 : 64'(stop);
   assign mq = sat_signed(m_p >> FRAC_BITS, neg_ff);
   assign dq = sat_signed(d_q, neg_ff);
   assign den10 = 64'(k2) * 64'sd10;
   assign rtry = rr_ff | (64'd1 << rb_ff[5:0]);

   always_comb begin
      st_in = st_ff;
      pt_in = pt_ff;
      rumax_in = rumax_ff;
      ru_in = ru_ff;
      ru2_in = ru2_ff;
      t1_in = t1_ff;
      slope_in = slope_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      s_in = s_ff;
      it_in = it_ff;
      bn_in = bn_ff;
      z2_in = z2_ff;
      acc_in = acc_ff;
      rb_in = rb_ff;
      rr_in = rr_ff;
      ox_in = ox_ff;
      oy_in = oy_ff;
      out_in = out_ff && !rsp_pop;
      neg_in = neg_ff;
      q_pop = 1'b0;
      m_start = 1'b0;
      m_a = '0;
      m_b = '0;
      d_start = 1'b0;
      d_num = '0;
      d_den = 64'd1;
      fval = '0;
      nxt = '0;
      unique case (st_ff)
         S_IDLE: begin
            if (!q_empty && !out_ff) begin
               pt_in = q_head;
               q_pop = 1'b1;
               if (q_head.rd == '0) begin
                  ox_in = '0;
                  oy_in = '0;
                  out_in = 1'b1;
               end else begin
                  st_in = S_L_K0;
               end
            end
         end
         S_L_K0: begin
            rumax_in = RU_CAP;
            if (k2 != '0) begin
               m_start = 1'b1;
               m_a = 64'(3) * mag(64'(k1));
               m_b = m_a;
               st_in = S_L_A;
            end else if (k1 < 0) begin
               d_start = 1'b1;
               d_num = 128'(ONE_Q) << (2 * FRAC_BITS);
               d_den = 64'(3) * mag(64'(k1));
               st_in = S_L_K2;
            end else begin
               st_in = S_N_START;
            end
         end
         S_L_K2: begin
            if (d_done) begin
               acc_in = d_q;
               rr_in = '0;
               rb_in = 7'd63;
               z2_in = 1'b1;
               st_in = S_L_RT2;
            end
         end
         S_L_A: begin
            if (m_done) begin
               acc_in = m_p;
               m_start = 1'b1;
               m_a = 64'd20;
               m_b = mag(64'(k2));
               st_in = S_L_B;
            end
         end
         S_L_B: begin
            if (m_done) begin
               if (k2 < 0) begin
                  acc_in = acc_ff + (m_p << FRAC_BITS);
                  rr_in = '0;
                  rb_in = 7'd63;
                  st_in = S_L_SQ;
               end else if ((m_p << FRAC_BITS) <= acc_ff) begin
                  acc_in = acc_ff - (m_p << FRAC_BITS);
                  rr_in = '0;
                  rb_in = 7'd63;
                  st_in = S_L_SQ;
               end else begin
                  st_in = S_N_START;
               end
            end
         end
         S_L_SQ: begin
            // integer square root of the discriminant, one bit per multiply
            if (rb_ff == 7'd63 && !m_done && !m_start && rr_ff == '0 && !z2_ff) begin
               z2_in = 1'b1;
               m_start = 1'b1;
               m_a = rtry;
               m_b = rtry;
            end else if (m_done) begin
               if (m_p <= acc_ff) rr_in = rtry;
               if (rb_ff == '0) begin
                  s_in = (m_p <= acc_ff) ? $signed(rtry) : $signed(rr_ff);
                  z2_in = 1'b0;
                  // bit 0 of ru2 flags a divide in flight for the next state
                  ru2_in = '0;
                  st_in = S_L_DIV;
               end else begin
                  rb_in = rb_ff - 7'd1;
                  m_start = 1'b1;
                  m_a = ((m_p <= acc_ff) ? rtry : rr_ff) | (64'd1 << (rb_ff[5:0] - 6'd1));
                  m_b = m_a;
               end
            end
         end
         S_L_DIV: begin
            // z = (-3k1 +/- s) / (10 k2), then root of each positive z
            if (!d_done && !z2_ff && !ru2_ff[0]) begin
               t1_in = z2_ff ? (-64'sd3 * 64'(k1) - s_ff) : (-64'sd3 * 64'(k1) + s_ff);
               d_start = 1'b1;
               d_num = 128'(mag(t1_in)) << FRAC_BITS;
               d_den = mag(den10);
               neg_in = t1_in[63] != den10[63];
               ru2_in = 64'sd1;
            end else if (d_done) begin
               ru2_in = '0;
               if (dq > 0) begin
                  acc_in = 128'(dq) << FRAC_BITS;
                  rr_in = '0;
                  rb_in = 7'd63;
                  st_in = S_L_RT;
                  m_start = 1'b1;
                  m_a = 64'd1 << 63;
                  m_b = m_a;
               end else if (z2_ff) begin
                  z2_in = 1'b0;
                  st_in = S_N_START;
               end else begin
                  z2_in = 1'b1;
                  t1_in = -64'sd3 * 64'(k1) - s_ff;
                  d_start = 1'b1;
                  d_num = 128'(mag(t1_in)) << FRAC_BITS;
                  d_den = mag(den10);
                  neg_in = t1_in[63] != den10[63];
               end
            end else if (z2_ff && !ru2_ff[0]) begin
               t1_in = -64'sd3 * 64'(k1) - s_ff;
               d_start = 1'b1;
               d_num = 128'(mag(t1_in)) << FRAC_BITS;
               d_den = mag(den10);
               neg_in = t1_in[63] != den10[63];
               ru2_in = 64'sd1;
            end
         end
         S_L_RT: begin
            if (m_done) begin
               if (m_p <= acc_ff) rr_in = rtry;
               if (rb_ff == '0) begin
                  nxt = (m_p <= acc_ff) ? $signed(rtry) : $signed(rr_ff);
                  if (nxt > RU_CAP) nxt = RU_CAP;
                  if (nxt < rumax_ff) rumax_in = nxt;
                  if (z2_ff) begin
                     z2_in = 1'b0;
                     st_in = S_N_START;
                  end else begin
                     z2_in = 1'b1;
                     st_in = S_L_DIV;
                  end
               end else begin
                  rb_in = rb_ff - 7'd1;
                  m_start = 1'b1;
                  m_a = ((m_p <= acc_ff) ? rtry : rr_ff) | (64'd1 << (rb_ff[5:0] - 6'd1));
                  m_b = m_a;
               end
            end
         end
         S_L_RT2: begin
            // root of 2^(3F)/(3|k1|), bit-serial with the shared multiplier
            if (z2_ff) begin
               z2_in = 1'b0;
               m_start = 1'b1;
               m_a = rtry;
               m_b = rtry;
            end else if (m_done) begin
               if (m_p <= acc_ff) rr_in = rtry;
               if (rb_ff == '0) begin
                  nxt = (m_p <= acc_ff) ? $signed(rtry) : $signed(rr_ff);
                  rumax_in = (nxt > RU_CAP) ? RU_CAP : nxt;
                  st_in = S_N_START;
               end else begin
                  rb_in = rb_ff - 7'd1;
                  m_start = 1'b1;
                  m_a = ((m_p <= acc_ff) ? rtry : rr_ff) | (64'd1 << (rb_ff[5:0] - 6'd1));
                  m_b = m_a;
               end
            end
         end
         S_N_START: begin
            ru_in = ($signed(pt_ff.rd) >= rumax_ff) ? (rumax_ff >>> 1) : $signed(pt_ff.rd);
            it_in = '0;
            m_start = 1'b1;
            m_a = mag(ru_in);
            m_b = m_a;
            neg_in = 1'b0;
            st_in = S_N_RU2;
         end
         S_N_RU2: begin
            if (m_done) begin
               ru2_in = mq;
               m_start = 1'b1;
               m_a = mag(64'(k2) * 64'sd5);
               m_b = mag(mq);
               neg_in = k2[31];
               st_in = S_N_P1;
            end
         end
         S_N_P1: begin
            // slope = 1 + ru2*(3k1 + 5k2*ru2)
            if (m_done) begin
               t1_in = sat_add(64'(k1) * 64'sd3, mq);
               m_start = 1'b1;
               m_a = mag(ru2_ff);
               m_b = mag(t1_in);
               neg_in = ru2_ff[63] != t1_in[63];
               st_in = S_N_P2;
            end
         end
         S_N_P2: begin
            if (m_done) begin
               slope_in = sat_add($signed(ONE_Q), mq);
               if (slope_in == '0) begin
                  st_in = S_B_START;
               end else begin
                  m_start = 1'b1;
                  m_a = mag(64'(k2));
                  m_b = mag(ru2_ff);
                  neg_in = k2[31] != ru2_ff[63];
                  st_in = S_N_Q1;
               end
            end
         end
         S_N_Q1: begin
            if (m_done) begin
               t1_in = sat_add(64'(k1), mq);
               m_start = 1'b1;
               m_a = mag(ru2_ff);
               m_b = mag(t1_in);
               neg_in = ru2_ff[63] != t1_in[63];
               st_in = S_N_Q2;
            end
         end
         S_N_Q2: begin
            if (m_done) begin
               t1_in = sat_add($signed(ONE_Q), mq);
               m_start = 1'b1;
               m_a = mag(ru_ff);
               m_b = mag(t1_in);
               neg_in = ru_ff[63] != t1_in[63];
               st_in = S_N_F;
            end
         end
         S_N_F: begin
            if (m_done) begin
               fval = sat_add(mq, -$signed(pt_ff.rd));
               d_start = 1'b1;
               d_num = 128'(mag(fval)) << FRAC_BITS;
               d_den = mag(slope_ff);
               neg_in = fval[63] != slope_ff[63];
               st_in = S_N_DIV;
            end
         end
         S_N_DIV: begin
            if (d_done) begin
               nxt = sat_add(ru_ff, -dq);
               ru_in = nxt;
               it_in = it_ff + SW'(1);
               if (nxt < 0 || nxt > rumax_ff) st_in = S_B_START;
               else if (32'(it_in) >= 32'(MAX_NEWTON_STEPS)) st_in = S_B_START;
               else if (mag(nxt - ru_ff) <= prec) st_in = S_O_MX;
               else begin
                  m_start = 1'b1;
                  m_a = mag(nxt);
                  m_b = m_a;
                  neg_in = 1'b0;
                  st_in = S_N_RU2;
               end
            end
         end
         S_B_START: begin
            lo_in = '0;
            hi_in = rumax_ff;
            ru_in = rumax_ff >>> 1;
            bn_in = '0;
            m_start = 1'b1;
            m_a = mag(ru_in);
            m_b = m_a;
            neg_in = 1'b0;
            st_in = S_B_RU2;
         end
         S_B_RU2: begin
            if (m_done) begin
               ru2_in = mq;
               m_start = 1'b1;
               m_a = mag(64'(k2));
               m_b = mag(mq);
               neg_in = k2[31] != mq[63];
               st_in = S_B_Q1;
            end
         end
         S_B_Q1: begin
            if (m_done) begin
               t1_in = sat_add(64'(k1), mq);
               m_start = 1'b1;
               m_a = mag(ru2_ff);
               m_b = mag(t1_in);
               neg_in = ru2_ff[63] != t1_in[63];
               st_in = S_B_Q2;
            end
         end
         S_B_Q2: begin
            if (m_done) begin
               t1_in = sat_add($signed(ONE_Q), mq);
               m_start = 1'b1;
               m_a = mag(ru_ff);
               m_b = mag(t1_in);
               neg_in = ru_ff[63] != t1_in[63];
               st_in = S_B_F;
            end
         end
         S_B_F: begin
            if (m_done) begin
               fval = sat_add(mq, -$signed(pt_ff.rd));
               if (fval == '0) begin
                  st_in = S_O_MX;
               end else begin
                  if (fval > 0) begin
                     nxt = (ru_ff + lo_ff) / 2;
                     hi_in = ru_ff;
                  end else begin
                     nxt = (hi_ff + ru_ff) / 2;
                     lo_in = ru_ff;
                  end
                  ru_in = nxt;
                  bn_in = bn_ff + 7'd1;
                  if (mag(nxt - ru_ff) <= prec || bn_in == 7'd64) st_in = S_O_MX;
                  else begin
                     m_start = 1'b1;
                     m_a = mag(nxt);
                     m_b = m_a;
                     neg_in = 1'b0;
                     st_in = S_B_RU2;
                  end
               end
            end
         end
         S_O_MX: begin
            m_start = 1'b1;
            m_a = mag(64'(pt_ff.x));
            m_b = 64'(ru_ff);
            st_in = S_O_DX;
         end
         S_O_DX: begin
            if (m_done) begin
               d_start = 1'b1;
               d_num = m_p;
               d_den = pt_ff.rd;
               st_in = S_O_MY;
            end
         end
         S_O_MY: begin
            if (d_done) begin
               ox_in = pt_ff.x[31]
                  ? ((d_q > 128'h8000_0000) ? 32'sh8000_0000 : 32'(-d_q[31:0]))
                  : ((d_q > 128'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(d_q[31:0]));
               m_start = 1'b1;
               m_a = mag(64'(pt_ff.y));
               m_b = 64'(ru_ff);
               st_in = S_O_DY;
            end
         end
         S_O_DY: begin
            if (m_done) begin
               d_start = 1'b1;
               d_num = m_p;
               d_den = pt_ff.rd;
               st_in = S_OUT;
            end
         end
         S_OUT: begin
            if (d_done) begin
               oy_in = pt_ff.y[31]
                  ? ((d_q > 128'h8000_0000) ? 32'sh8000_0000 : 32'(-d_q[31:0]))
                  : ((d_q > 128'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(d_q[31:0]));
               out_in = 1'b1;
               st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         out_ff <= 1'b0;
         z2_ff <= 1'b0;
         ru2_ff <= '0;
      end else begin
         st_ff <= st_in;
         out_ff <= out_in;
         z2_ff <= z2_in;
         ru2_ff <= ru2_in;
      end
      pt_ff <= pt_in;
      rumax_ff <= rumax_in;
      ru_ff <= ru_in;
      t1_ff <= t1_in;
      slope_ff <= slope_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      s_ff <= s_in;
      it_ff <= it_in;
      bn_ff <= bn_in;
      acc_ff <= acc_in;
      rb_ff <= rb_in;
      rr_ff <= rr_in;
      ox_ff <= ox_in;
      oy_ff <= oy_in;
      neg_ff <= neg_in;
   end
endmodule

// File: sv/inverse_radial_distortion_top.sv
// top level of the inverse radial distortion block
// channel   ports                             beat
// request   req_push / req_full               dist_x, dist_y
// response  rsp_empty / rsp_pop               undist_x, undist_y
// csr       csr_we, csr_idx, csr_wdata        k1, k2, stop_step
// the front computes the radius root bit by bit and queues two points
// the back takes one point at a time: each newton step needs six multiplies and
// one divide on the shared units
// reset is synchronous and clears the queue, sequencers and csr to their defaults
// one result waits in the output register; the back stalls until it is popped
module inverse_radial_distortion_top #(
   parameter int FRAC_BITS = 24,
   parameter int MAX_NEWTON_STEPS = 100
) (
   input logic clock,
   input logic reset,
   input logic req_push,
   output logic req_full,
   input logic signed [ird_pkg::WORD_W-1:0] req_dist_x,
   input logic signed [ird_pkg::WORD_W-1:0] req_dist_y,
   output logic rsp_empty,
   input logic rsp_pop,
   output logic signed [ird_pkg::WORD_W-1:0] rsp_undist_x,
   output logic signed [ird_pkg::WORD_W-1:0] rsp_undist_y,
   input logic csr_we,
   input logic [ird_pkg::CSR_IDX_W-1:0] csr_idx,
   input logic [ird_pkg::WORD_W-1:0] csr_wdata
);
   import ird_pkg::*;

   logic signed [WORD_W-1:0] k1_ff, k2_ff;
   logic [STOP_W-1:0] stop_ff;
   logic q_empty, q_pop;
   pt_type q_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         k1_ff <= '0;
         k2_ff <= '0;
         stop_ff <= STOP_W'(1);
      end else if (csr_we) begin
         unique case (csr_idx)
            CSR_K1: k1_ff <= $signed(csr_wdata);
            CSR_K2: k2_ff <= $signed(csr_wdata);
            CSR_STOP: stop_ff <= csr_wdata[STOP_W-1:0];
            default: ;
         endcase
      end
   end

   ird_front u_front (
      .clock, .reset, .push(req_push), .full(req_full), .dist_x(req_dist_x),
      .dist_y(req_dist_y), .q_empty, .q_pop, .q_head
   );

   ird_back #(.FRAC_BITS(FRAC_BITS), .MAX_NEWTON_STEPS(MAX_NEWTON_STEPS)) u_back (
      .clock, .reset, .k1(k1_ff), .k2(k2_ff), .stop(stop_ff), .q_empty, .q_pop, .q_head,
      .rsp_empty, .rsp_pop, .undist_x(rsp_undist_x), .undist_y(rsp_undist_y)
   );
endmodule

// File: dv/tb_inverse_radial_distortion_top.sv
// testbench for the inverse radial distortion block: random traffic against a fixed-point predictor
`timescale 1ns / 100ps

module tb_inverse_radial_distortion_top;
   import ird_pkg::*;

   localparam int FRAC = 24;
   localparam int NEWTON_MAX = 100;
   localparam int BISECT_MAX = 64;
   localparam int ITEMS_PER_PHASE = 64;
   localparam int WATCHDOG_LIMIT = 200000;
   localparam longint unsigned SATM = 64'h3FFF_FFFF_FFFF_FFFF;
   localparam longint RADIUS_CAP = 64'h0000_00FF_FFFF_FFFF;

   typedef struct {
      logic signed [WORD_W-1:0] x;
      logic signed [WORD_W-1:0] y;
   } point_type;

   class undistort_board;
      longint k1;
      longint k2;
      longint unsigned stop_lsb;
      point_type want_q[$];
      int errors;
      int checked;

      function new();
         k1 = 0;
         k2 = 0;
         stop_lsb = 1;
         errors = 0;
         checked = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [WORD_W-1:0] v);
         case (idx)
            CSR_K1: k1 = longint'($signed(v));
            CSR_K2: k2 = longint'($signed(v));
            CSR_STOP: stop_lsb = {33'd0, v[STOP_W-1:0]};
            default: ;
         endcase
      endfunction

      function longint unsigned umag(longint v);
         return v < 0 ? longint'(-v) : v;
      endfunction

      function longint unsigned isqrt(logic [127:0] v);
         longint unsigned r;
         longint unsigned t;
         logic [127:0] sq;
         r = 0;
         for (int b = 63; b >= 0; b--) begin
            t = r | (64'd1 << b);
            sq = {64'd0, t} * {64'd0, t};
            if (sq <= v) r = t;
         end
         return r;
      endfunction

      function longint satq(logic [127:0] m, bit neg);
         longint unsigned v;
         v = (m[127:64] != 0 || m[63:0] > SATM) ? SATM : m[63:0];
         return neg ? -longint'(v) : longint'(v);
      endfunction

      function longint sadd(longint a, longint b);
         longint s;
         s = a + b;
         if (s > longint'(SATM)) return longint'(SATM);
         if (s < -longint'(SATM)) return -longint'(SATM);
         return s;
      endfunction

      function longint mulq(longint a, longint b);
         logic [127:0] p;
         p = {64'd0, umag(a)} * {64'd0, umag(b)};
         return satq(p >> FRAC, (a < 0) != (b < 0));
      endfunction

      function longint divq(longint a, longint b);
         logic [127:0] p;
         p = {64'd0, umag(a)} << FRAC;
         p = p / {64'd0, umag(b)};
         return satq(p, (a < 0) != (b < 0));
      endfunction

      function longint capr(longint unsigned r);
         return r > RADIUS_CAP ? RADIUS_CAP : longint'(r);
      endfunction

      function longint sqrtq(longint z);
         return capr(isqrt({64'd0, z} << FRAC));
      endfunction

      // 1 + r2*(c1 + c2*r2)
      function longint poly(longint r2, longint c1, longint c2);
         return sadd(longint'(1) << FRAC, mulq(r2, sadd(c1, mulq(c2, r2))));
      endfunction

      // largest radius where the distortion stays monotonic
      function longint radius_max();
         longint lim;
         longint s;
         longint den;
         longint z;
         longint r;
         longint unsigned t;
         logic [127:0] a;
         logic [127:0] b;
         logic [127:0] rad;
         lim = RADIUS_CAP;
         if (k2 != 0) begin
            t = 3 * umag(k1);
            a = {64'd0, t} * {64'd0, t};
            b = {64'd0, 64'(20 * umag(k2))} << FRAC;
            if (k2 < 0) rad = a + b;
            else if (b <= a) rad = a - b;
            else return lim;
            s = longint'(isqrt(rad));
            den = 10 * k2;
            z = divq(-3 * k1 + s, den);
            if (z > 0) begin
               r = sqrtq(z);
               if (r < lim) lim = r;
            end
            z = divq(-3 * k1 - s, den);
            if (z > 0) begin
               r = sqrtq(z);
               if (r < lim) lim = r;
            end
         end else if (k1 < 0) begin
            lim = capr(isqrt((128'd1 << (3 * FRAC)) / {64'd0, 64'(3 * umag(k1))}));
         end
         return lim;
      endfunction

      function logic [WORD_W-1:0] scale(longint d, longint ru, longint rd);
         logic [127:0] p;
         longint unsigned lim;
         longint unsigned v;
         p = ({64'd0, umag(d)} * {64'd0, 64'(ru)}) / {64'd0, 64'(rd)};
         lim = d < 0 ? 64'h8000_0000 : 64'h7FFF_FFFF;
         v = (p[127:64] != 0 || p[63:0] > lim) ? lim : p[63:0];
         return d < 0 ? WORD_W'(-v) : WORD_W'(v);
      endfunction

      function point_type undistort(logic signed [WORD_W-1:0] xi,
                                    logic signed [WORD_W-1:0] yi);
         point_type res;
         longint xd, yd, rd, rmax, ru, ru2, slope, nxt, f, lo, hi, k1x3, k2x5;
         longint unsigned prec, step, mx, my;
         bit bad;
         int it;
         xd = xi;
         yd = yi;
         mx = umag(xd);
         my = umag(yd);
         prec = stop_lsb == 0 ? 1 : stop_lsb;
         rd = longint'(isqrt({64'd0, mx} * {64'd0, mx} + {64'd0, my} * {64'd0, my}));
         if (rd == 0) begin
            res.x = 0;
            res.y = 0;
            return res;
         end
         rmax = radius_max();
         k1x3 = 3 * k1;
         k2x5 = 5 * k2;
         ru = rd >= rmax ? rmax / 2 : rd;
         bad = 0;
         it = 0;
         forever begin
            ru2 = mulq(ru, ru);
            slope = poly(ru2, k1x3, k2x5);
            if (slope == 0) begin
               bad = 1;
               break;
            end
            nxt = sadd(ru, -divq(sadd(mulq(ru, poly(ru2, k1, k2)), -rd), slope));
            step = umag(nxt - ru);
            ru = nxt;
            if (ru < 0 || ru > rmax) begin
               bad = 1;
               break;
            end
            it++;
            if (it >= NEWTON_MAX) begin
               bad = 1;
               break;
            end
            if (step <= prec) break;
         end
         // fall back to bisection over the whole monotonic range
         if (bad) begin
            lo = 0;
            hi = rmax;
            ru = rmax / 2;
            for (int n = 0; n < BISECT_MAX; n++) begin
               f = sadd(mulq(ru, poly(mulq(ru, ru), k1, k2)), -rd);
               if (f > 0) begin
                  nxt = (ru + lo) / 2;
                  hi = ru;
               end else if (f < 0) begin
                  nxt = (hi + ru) / 2;
                  lo = ru;
               end else begin
                  break;
               end
               step = umag(nxt - ru);
               ru = nxt;
               if (step <= prec) break;
            end
         end
         res.x = scale(xd, ru, rd);
         res.y = scale(yd, ru, rd);
         return res;
      endfunction

      function void note_point(logic signed [WORD_W-1:0] x, logic signed [WORD_W-1:0] y);
         want_q.push_back(undistort(x, y));
      endfunction

      function void check_point(logic signed [WORD_W-1:0] x, logic signed [WORD_W-1:0] y);
         point_type w;
         if (want_q.size() == 0) begin
            $error("result beat with no point outstanding: x=%0d y=%0d", x, y);
            errors++;
            return;
         end
         w = want_q.pop_front();
         checked++;
         if (x !== w.x) begin
            $error("undist_x expected %0d actual %0d", w.x, x);
            errors++;
         end
         if (y !== w.y) begin
            $error("undist_y expected %0d actual %0d", w.y, y);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic signed [WORD_W-1:0] req_dist_x = '0;
   logic signed [WORD_W-1:0] req_dist_y = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic signed [WORD_W-1:0] rsp_undist_x;
   logic signed [WORD_W-1:0] rsp_undist_y;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_idx = '0;
   logic [WORD_W-1:0] csr_wdata = '0;

   undistort_board board = new();
   int idle_cycles = 0;
   int sent = 0;

   inverse_radial_distortion_top uut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_dist_x(req_dist_x),
      .req_dist_y(req_dist_y),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_undist_x(rsp_undist_x),
      .rsp_undist_y(rsp_undist_y),
      .csr_we(csr_we),
      .csr_idx(csr_idx),
      .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || csr_we || reset) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d points outstanding",
                     WATCHDOG_LIMIT, board.want_q.size());
            $display("simulation failed");
            $finish;
         end
      end
   end

   // result side: random stalls, checks every popped beat
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         board.check_point(rsp_undist_x, rsp_undist_y);
      end
   end

   task automatic send_point(logic signed [WORD_W-1:0] x, logic signed [WORD_W-1:0] y,
                             int gap);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_dist_x <= x;
      req_dist_y <= y;
      do @(posedge clock); while (req_full);
      board.note_point(x, y);
      sent++;
   endtask

   task automatic drain();
      req_push <= 1'b0;
      while (board.want_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // back-to-back register writes, plus one to the unused index
   task automatic program_coefs(logic [WORD_W-1:0] k1, logic [WORD_W-1:0] k2,
                                logic [WORD_W-1:0] stop);
      logic [WORD_W-1:0] vals [4];
      logic [CSR_IDX_W-1:0] idxs [4];
      vals = '{k1, k2, stop, $urandom()};
      idxs = '{CSR_K1, CSR_K2, CSR_STOP, CSR_IDX_W'(3)};
      for (int i = 0; i < 4; i++) begin
         csr_we <= 1'b1;
         csr_idx <= idxs[i];
         csr_wdata <= vals[i];
         @(posedge clock);
         board.set_reg(idxs[i], vals[i]);
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic int gap_draw();
      return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
   endfunction

   function automatic logic [WORD_W-1:0] coord_draw();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick < 6) return WORD_W'(int'($urandom_range(0, 1 << 26)) - (1 << 25));
      if (pick < 9) return WORD_W'(int'($urandom_range(0, 1 << 29)) - (1 << 28));
      return $urandom();
   endfunction

   initial begin
      logic [WORD_W-1:0] cfg [7][3];
      cfg = '{
         '{32'h0000_0000, 32'h0000_0000, 32'h0000_0001},
         '{32'h0199_999A, 32'h0028_F5C3, 32'h0000_0001},
         '{32'hFFCC_CCCD, 32'h0000_0000, 32'h0000_0010},
         '{32'hFFC0_0000, 32'h0008_0000, 32'h0000_0001},
         '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF},
         '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001},
         '{32'h0020_0000, 32'hFFF0_0000, 32'h0000_0100}
      };
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults first, with the corner points
      send_point(0, 0, 0);
      send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0);
      send_point(32'sh8000_0000, 32'sh8000_0000, 1);
      send_point(32'sh8000_0000, 0, 0);
      send_point(0, 32'sh7FFF_FFFF, 2);
      send_point(1, 0, 0);
      send_point(-1, -1, 0);
      send_point(32'sh0100_0000, 0, 3);
      send_point(0, -32'sh0100_0000, 0);
      send_point(32'sh0080_0000, 32'sh0080_0000, 0);
      drain();

      for (int ph = 0; ph < 7; ph++) begin
         program_coefs(cfg[ph][0], cfg[ph][1], cfg[ph][2]);
         send_point(0, 0, 0);
         send_point(32'sh7FFF_FFFF, 32'sh8000_0000, gap_draw());
         send_point(32'sh0100_0000, 32'sh0100_0000, gap_draw());
         send_point(-3, 4, gap_draw());
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            // some runs of back-to-back beats, else random gaps
            send_point(coord_draw(), coord_draw(), (ph % 2 == 0 && i < 12) ? 0 : gap_draw());
         end
         drain();
      end

      repeat (50) @(posedge clock);
      $display("sent %0d points over 8 coefficient settings, %0d results compared",
               sent, board.checked);
      if (board.errors == 0 && board.want_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
